// ===== rtl/core/pfx_pkg.sv =====
// Shared constants, types and codes of the protobuf field-one extractor.
package pfx_pkg;

   localparam int unsigned PAYLOAD_DEPTH = 64;
   localparam int unsigned ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(PAYLOAD_DEPTH + 1);
   localparam int unsigned VAR_W = 64;
   localparam int unsigned SHIFT_W = 7;

   localparam logic [7:0] VAR_DATA_MASK = 8'h7F;
   localparam logic [7:0] VAR_CONT_MASK = 8'h80;
   localparam logic [7:0] WIRE_TYPE_MASK = 8'h07;

   localparam logic [SHIFT_W-1:0] VARINT_STEP = 7'd7;
   localparam logic [SHIFT_W-1:0] VARINT_LIMIT = 7'd64;

   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_FIX64 = 3'd1;
   localparam logic [2:0] WT_LEN = 3'd2;
   localparam logic [2:0] WT_FIX32 = 3'd5;

   localparam logic [VAR_W-1:0] FIX64_BYTES = 64'd8;
   localparam logic [VAR_W-1:0] FIX32_BYTES = 64'd4;

   localparam logic [4:0] TARGET_FIELD = 5'd1;

   typedef enum logic [2:0] {
      PH_TAG  = 3'd0,
      PH_LEN  = 3'd1,
      PH_VAR  = 3'd2,
      PH_SKIP = 3'd3,
      PH_PAY  = 3'd4,
      PH_DONE = 3'd5,
      PH_HALT = 3'd6
   } phase_type;

   typedef enum logic {
      EM_IDLE = 1'b0,
      EM_SHOW = 1'b1
   } em_state_type;

   typedef enum logic [1:0] {
      ST_DATA = 2'd0,
      ST_NOID = 2'd1,
      ST_LONG = 2'd2
   } status_type;

   typedef struct packed {
      logic             valid;
      status_type       status;
      logic [CNT_W-1:0] count;
   } job_type;

endpackage

// ===== rtl/core/pfx_if.sv =====
// Valid/ready channel interfaces for message bytes and answer results.
interface pfx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface pfx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] out_status;
   logic       out_last;

   modport source (output valid, output out_byte, output out_status, output out_last,
                   input ready);
   modport sink (input valid, input out_byte, input out_status, input out_last,
                 output ready);
endinterface

// ===== rtl/core/pfx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pfx_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                             rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pfx_parser.sv =====
// Wire-format scanner: walks tags, varints and skips, stores field 1 and posts answer jobs.
module pfx_parser (
   input  logic                        clock,
   input  logic                        reset,
   pfx_req_if.sink                     req_ch,
   input  logic                        emit_busy,
   output logic                        ram_wr_en,
   output logic [pfx_pkg::ADDR_W-1:0]  ram_wr_addr,
   output logic [7:0]                  ram_wr_data,
   output pfx_pkg::job_type            job
);
   import pfx_pkg::*;

   phase_type        phase_ff, phase_in, phase_step;
   logic [VAR_W-1:0] varint_ff, varint_in, varint_acc;
   logic [SHIFT_W-1:0] shift_ff, shift_in, shift_acc, shift_sum;
   logic             target_ff, target_in;
   logic [VAR_W-1:0] skip_ff, skip_in, skip_dec;
   logic [CNT_W-1:0] count_ff, count_in, count_inc;
   logic             oversize_ff, oversize_in;
   job_type          job_ff, job_in;

   logic       accept;
   logic       var_end;
   logic       len_zero;
   logic       len_over;
   logic       skip_end;
   logic       store_ok;
   logic [2:0] wire_kind;
   logic [4:0] tag_field;

   assign req_ch.ready = !emit_busy && !job_ff.valid;
   assign accept = req_ch.valid && req_ch.ready;

   assign wire_kind = 3'(req_ch.in_byte & WIRE_TYPE_MASK);
   assign tag_field = req_ch.in_byte[7:3];

   assign shift_sum = shift_ff + VARINT_STEP;
   assign varint_acc = (shift_ff < VARINT_LIMIT)
                     ? (varint_ff | (VAR_W'(req_ch.in_byte & VAR_DATA_MASK) << shift_ff[5:0]))
                     : varint_ff;
   assign shift_acc = (shift_ff < VARINT_LIMIT)
                    ? ((shift_sum > VARINT_LIMIT) ? VARINT_LIMIT : shift_sum)
                    : shift_ff;
   assign var_end = (req_ch.in_byte & VAR_CONT_MASK) == 8'h00;
   assign len_zero = varint_acc == '0;
   assign len_over = varint_acc > VAR_W'(PAYLOAD_DEPTH);

   assign skip_dec = (skip_ff != '0) ? (skip_ff - VAR_W'(1)) : skip_ff;
   assign skip_end = skip_dec == '0;

   assign store_ok = !oversize_ff && (count_ff < CNT_W'(PAYLOAD_DEPTH));
   assign count_inc = count_ff + CNT_W'(1);

   // next state
   always_comb begin
      phase_step = phase_ff;
      unique case (phase_ff)
         PH_TAG: begin
            priority if (wire_kind == WT_LEN) begin
               phase_step = PH_LEN;
            end else if (wire_kind == WT_VARINT) begin
               phase_step = PH_VAR;
            end else if (wire_kind == WT_FIX32 || wire_kind == WT_FIX64) begin
               phase_step = PH_SKIP;
            end else begin
               phase_step = PH_HALT;
            end
         end
         PH_LEN: begin
            if (var_end) begin
               if (target_ff) begin
                  phase_step = len_zero ? PH_DONE : PH_PAY;
               end else begin
                  phase_step = len_zero ? PH_TAG : PH_SKIP;
               end
            end
         end
         PH_VAR: begin
            if (var_end) begin
               phase_step = PH_TAG;
            end
         end
         PH_SKIP: begin
            if (skip_end) begin
               phase_step = PH_TAG;
            end
         end
         PH_PAY: begin
            if (skip_end) begin
               phase_step = PH_DONE;
            end
         end
         PH_DONE, PH_HALT: begin
            phase_step = phase_ff;
         end
         default: begin
            phase_step = PH_TAG;
         end
      endcase

      phase_in = phase_ff;
      if (accept) begin
         phase_in = req_ch.in_last ? PH_TAG : phase_step;
      end
   end

   // datapath and outputs
   always_comb begin
      varint_in   = varint_ff;
      shift_in    = shift_ff;
      target_in   = target_ff;
      skip_in     = skip_ff;
      count_in    = count_ff;
      oversize_in = oversize_ff;
      ram_wr_en   = 1'b0;
      job_in      = '{valid: 1'b0, status: ST_DATA, count: '0};

      if (accept) begin
         unique case (phase_ff)
            PH_TAG: begin
               varint_in = '0;
               shift_in  = '0;
               priority if (wire_kind == WT_LEN) begin
                  target_in = tag_field == TARGET_FIELD;
               end else if (wire_kind == WT_FIX32) begin
                  skip_in = FIX32_BYTES;
               end else if (wire_kind == WT_FIX64) begin
                  skip_in = FIX64_BYTES;
               end else begin
                  skip_in = skip_ff;
               end
            end
            PH_LEN: begin
               varint_in = varint_acc;
               shift_in  = shift_acc;
               if (var_end) begin
                  if (target_ff) begin
                     if (len_zero) begin
                        job_in = '{valid: 1'b1, status: ST_NOID, count: '0};
                     end else begin
                        oversize_in = len_over;
                        skip_in     = varint_acc;
                        count_in    = '0;
                     end
                  end else if (!len_zero) begin
                     skip_in = varint_acc;
                  end
               end
            end
            PH_VAR: begin
               varint_in = varint_acc;
               shift_in  = shift_acc;
            end
            PH_SKIP: begin
               skip_in = skip_dec;
            end
            PH_PAY: begin
               skip_in = skip_dec;
               if (store_ok) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_inc;
               end
               if (skip_end) begin
                  job_in = '{valid: 1'b1,
                             status: oversize_ff ? ST_LONG : ST_DATA,
                             count: store_ok ? count_inc : count_ff};
               end
            end
            default: begin
               skip_in = skip_ff;
            end
         endcase

         if (req_ch.in_last) begin
            if (!job_in.valid && phase_step != PH_DONE) begin
               job_in = '{valid: 1'b1, status: ST_NOID, count: '0};
            end
            varint_in   = '0;
            shift_in    = '0;
            target_in   = 1'b0;
            skip_in     = '0;
            count_in    = '0;
            oversize_in = 1'b0;
         end
      end
   end

   assign ram_wr_addr = count_ff[ADDR_W-1:0];
   assign ram_wr_data = req_ch.in_byte;
   assign job = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TAG;
         varint_ff   <= '0;
         shift_ff    <= '0;
         target_ff   <= 1'b0;
         skip_ff     <= '0;
         count_ff    <= '0;
         oversize_ff <= 1'b0;
         job_ff      <= '{valid: 1'b0, status: ST_DATA, count: '0};
      end else begin
         phase_ff    <= phase_in;
         varint_ff   <= varint_in;
         shift_ff    <= shift_in;
         target_ff   <= target_in;
         skip_ff     <= skip_in;
         count_ff    <= count_in;
         oversize_ff <= oversize_in;
         job_ff      <= job_in;
      end
   end

endmodule

// ===== rtl/core/pfx_emitter.sv =====
// Answer sequencer: reads stored payload back from the RAM and drives the result channel.
module pfx_emitter (
   input  logic                        clock,
   input  logic                        reset,
   input  pfx_pkg::job_type            job,
   output logic                        busy,
   output logic                        ram_rd_en,
   output logic [pfx_pkg::ADDR_W-1:0]  ram_rd_addr,
   input  logic [7:0]                  ram_rd_data,
   pfx_rsp_if.source                   rsp_ch
);
   import pfx_pkg::*;

   em_state_type      state_ff, state_in;
   status_type        status_ff, status_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;

   logic run_end;
   logic res_last;
   logic transfer;

   assign run_end  = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign res_last = (status_ff != ST_DATA) || run_end;
   assign transfer = rsp_ch.valid && rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EM_IDLE: begin
            if (job.valid) begin
               state_in = EM_SHOW;
            end
         end
         EM_SHOW: begin
            if (transfer && res_last) begin
               state_in = EM_IDLE;
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      status_in   = status_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;
      unique case (state_ff)
         EM_IDLE: begin
            if (job.valid) begin
               status_in   = job.status;
               count_in    = job.count;
               idx_in      = '0;
               ram_rd_en   = job.status == ST_DATA;
               ram_rd_addr = '0;
            end
         end
         EM_SHOW: begin
            if (transfer && !res_last) begin
               idx_in      = idx_ff + ADDR_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + ADDR_W'(1);
            end
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   assign busy              = state_ff != EM_IDLE;
   assign rsp_ch.valid      = state_ff == EM_SHOW;
   assign rsp_ch.out_byte   = (status_ff == ST_DATA) ? ram_rd_data : 8'h00;
   assign rsp_ch.out_status = status_ff;
   assign rsp_ch.out_last   = res_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      count_ff  <= count_in;
      idx_ff    <= idx_in;
   end

endmodule

// ===== rtl/core/protobuf_field_one_extractor.sv =====
// Top level of the protobuf field-one extractor: scanner, payload RAM and answer sequencer.
//
//   channel  direction  payload                           transfer on
//   req_ch   in         in_byte[7:0], in_last             valid && ready
//   rsp_ch   out        out_byte[7:0], out_status[1:0],   valid && ready
//                       out_last
//
// One message byte per cycle while scanning; req_ch.ready drops in the cycle after
// the byte that completes an answer, then stays low until its last result transfers.
// A payload answer gives one result per cycle from the RAM read port while rsp_ch.ready
// is high; a single no-id or too-long answer takes one result.
// Reset is synchronous; the payload RAM has no clearing pass and is only read where written.
// A stall on rsp_ch holds the result and keeps req_ch stalled.
module protobuf_field_one_extractor (
   input  logic       clock,
   input  logic       reset,
   pfx_req_if.sink    req_ch,
   pfx_rsp_if.source  rsp_ch
);
   import pfx_pkg::*;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic              emit_busy;
   job_type           job;

   pfx_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .emit_busy   (emit_busy),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .job         (job)
   );

   pfx_ram #(
      .Width (8),
      .Depth (PAYLOAD_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pfx_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .job         (job),
      .busy        (emit_busy),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ===== rtl/core/pfx_checker.sv =====
// Port-level checks on the field-one extractor and their binding to the top level.
module pfx_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_out_status,
   input logic       rsp_out_last
);
   import pfx_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_status) && $stable(rsp_out_last))
      else $error("stalled result changed");

   a_no_input_during_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while an answer is pending");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_status != ST_DATA |-> rsp_out_last && rsp_out_byte == 8'h00)
      else $error("status result is not a single zero-byte result");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_out_last |=> rsp_valid && rsp_out_status == ST_DATA)
      else $error("payload run broken before its last byte");

endmodule

bind protobuf_field_one_extractor pfx_checker u_pfx_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_byte   (rsp_ch.out_byte),
   .rsp_out_status (rsp_ch.out_status),
   .rsp_out_last   (rsp_ch.out_last)
);
